// ----- rtl/core/gcpc_pkg.sv -----
// Shared types, widths and constants for the grid cell polar converter.
// No dependencies; every other file in rtl/core refers to this package by scoped name.
package gcpc_pkg;

    // Grid and field widths
    localparam int GRID_DIM     = 512;
    localparam int IDX_W        = 9;
    localparam int HALF_W       = 7;
    localparam int PROD_W       = 17;
    localparam int COORD_W      = 21;
    localparam int MAG_W        = 18;
    localparam int D2_W         = 36;
    localparam int SQR_W        = 32;
    localparam int DIST_W       = 25;
    localparam int BEAR_W       = 15;
    localparam int CFG_DATA_W   = 16;
    localparam int CFG_IDX_W    = 3;

    // CORDIC and square root datapath
    localparam int CORDIC_STEPS = 24;
    localparam int CX_W         = 46;
    localparam int Z_W          = 27;
    localparam int SQ_W         = 48;

    // Pipeline depth: front end, CORDIC/root stages, output register
    localparam int FRONT_DEPTH  = 5;
    localparam int PIPE_DEPTH   = FRONT_DEPTH + CORDIC_STEPS + 1;

    // Angle constants
    localparam logic signed [Z_W-1:0] ANG_QUARTER  = 27'sd23592960;
    localparam logic [BEAR_W:0]       BEAR_QUARTER = 16'd5760;
    localparam logic [BEAR_W:0]       BEAR_HALF    = 16'd11520;
    localparam logic [BEAR_W:0]       BEAR_FULL    = 16'd23040;
    localparam logic [Z_W-1:0]        ANG_ROUND    = 27'd2048;

    // Reset values of the configuration registers
    localparam logic signed [CFG_DATA_W-1:0] RST_CORNER_X  = -16'sd3000;
    localparam logic signed [CFG_DATA_W-1:0] RST_CORNER_Y  = 16'sd3000;
    localparam logic [7:0]                   RST_CELL_SIZE = 8'd20;
    localparam logic [CFG_DATA_W-1:0]        RST_MAX_RANGE = 16'd3000;
    localparam logic [CFG_DATA_W-1:0]        RST_MIN_RANGE = 16'd150;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CORNER_X  = 3'd0,
        CFG_CORNER_Y  = 3'd1,
        CFG_CELL_SIZE = 3'd2,
        CFG_MAX_RANGE = 3'd3,
        CFG_MIN_RANGE = 3'd4
    } t_cfg_reg;

    // Front end result: centre, magnitudes, squared distance
    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic [MAG_W-1:0]          ax;
        logic [MAG_W-1:0]          ay;
        logic [D2_W-1:0]           d2;
        logic                      grid_ok;
    } t_front;

    // Sideband that rides along the CORDIC stages
    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic                      in_range;
        logic                      ax_zero;
        logic                      ay_zero;
    } t_side;

    // atan(2^-i) in units of 2^-18 degree, rounded to nearest
    function automatic logic signed [Z_W-1:0] atan_val(input int unsigned idx);
        logic signed [Z_W-1:0] v;
        case (idx)
            0:       v = 27'sd11796480;
            1:       v = 27'sd6963869;
            2:       v = 27'sd3679517;
            3:       v = 27'sd1867780;
            4:       v = 27'sd937515;
            5:       v = 27'sd469214;
            6:       v = 27'sd234664;
            7:       v = 27'sd117339;
            8:       v = 27'sd58671;
            9:       v = 27'sd29335;
            10:      v = 27'sd14668;
            11:      v = 27'sd7334;
            12:      v = 27'sd3667;
            13:      v = 27'sd1833;
            14:      v = 27'sd917;
            15:      v = 27'sd458;
            16:      v = 27'sd229;
            17:      v = 27'sd115;
            18:      v = 27'sd57;
            19:      v = 27'sd29;
            20:      v = 27'sd14;
            21:      v = 27'sd7;
            22:      v = 27'sd4;
            23:      v = 27'sd2;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

// ----- rtl/core/gcpc_front.sv -----
// Front end: cell centre, absolute coordinates, squares and squared distance.
// Five register stages sharing one advance enable; depends on gcpc_pkg.
module gcpc_front (
    input  logic                                   i_clk,
    input  logic                                   i_en,
    input  logic [gcpc_pkg::IDX_W-1:0]             i_row,
    input  logic [gcpc_pkg::IDX_W-1:0]             i_col,
    input  logic signed [gcpc_pkg::CFG_DATA_W-1:0] i_corner_x,
    input  logic signed [gcpc_pkg::CFG_DATA_W-1:0] i_corner_y,
    input  logic [gcpc_pkg::HALF_W-1:0]            i_half,
    output gcpc_pkg::t_front                       o_front
);

    logic [gcpc_pkg::PROD_W-1:0]         r_a_px, r_a_py;
    logic                                r_a_ok, r_b_ok, r_c_ok, r_d_ok, r_e_ok;
    logic signed [gcpc_pkg::COORD_W-1:0] r_b_x, r_b_y, r_c_x, r_c_y, r_d_x, r_d_y;
    logic signed [gcpc_pkg::COORD_W-1:0] r_e_x, r_e_y;
    logic [gcpc_pkg::MAG_W-1:0]          r_c_ax, r_c_ay, r_d_ax, r_d_ay, r_e_ax, r_e_ay;
    logic [gcpc_pkg::D2_W-1:0]           r_d_sqx, r_d_sqy, r_e_d2;

    // Stage A: odd multiples of the half cell, grid bound check
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a_px <= {7'b0, i_row, 1'b1} * {10'b0, i_half};
            r_a_py <= {7'b0, i_col, 1'b1} * {10'b0, i_half};
            r_a_ok <= (32'(i_row) < gcpc_pkg::GRID_DIM) && (32'(i_col) < gcpc_pkg::GRID_DIM);
        end
    end

    // Stage B: offset from the grid corner
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_b_x  <= gcpc_pkg::COORD_W'(i_corner_x) + $signed({4'b0, r_a_px});
            r_b_y  <= gcpc_pkg::COORD_W'(i_corner_y) - $signed({4'b0, r_a_py});
            r_b_ok <= r_a_ok;
        end
    end

    // Stage C: magnitudes
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_c_ax <= r_b_x[gcpc_pkg::COORD_W-1] ? gcpc_pkg::MAG_W'(-r_b_x)
                                                 : gcpc_pkg::MAG_W'(r_b_x);
            r_c_ay <= r_b_y[gcpc_pkg::COORD_W-1] ? gcpc_pkg::MAG_W'(-r_b_y)
                                                 : gcpc_pkg::MAG_W'(r_b_y);
            r_c_x  <= r_b_x;
            r_c_y  <= r_b_y;
            r_c_ok <= r_b_ok;
        end
    end

    // Stage D: squares
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_d_sqx <= gcpc_pkg::D2_W'(r_c_ax) * gcpc_pkg::D2_W'(r_c_ax);
            r_d_sqy <= gcpc_pkg::D2_W'(r_c_ay) * gcpc_pkg::D2_W'(r_c_ay);
            r_d_ax  <= r_c_ax;
            r_d_ay  <= r_c_ay;
            r_d_x   <= r_c_x;
            r_d_y   <= r_c_y;
            r_d_ok  <= r_c_ok;
        end
    end

    // Stage E: squared distance
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_e_d2 <= r_d_sqx + r_d_sqy;
            r_e_ax <= r_d_ax;
            r_e_ay <= r_d_ay;
            r_e_x  <= r_d_x;
            r_e_y  <= r_d_y;
            r_e_ok <= r_d_ok;
        end
    end

    assign o_front.x       = r_e_x;
    assign o_front.y       = r_e_y;
    assign o_front.ax      = r_e_ax;
    assign o_front.ay      = r_e_ay;
    assign o_front.d2      = r_e_d2;
    assign o_front.grid_ok = r_e_ok;

endmodule

// ----- rtl/core/gcpc_cordic.sv -----
// Vectoring CORDIC, one micro-rotation per register stage, first quadrant.
// Gives the raw angle accumulator in 2^-18 degree; depends on gcpc_pkg.
module gcpc_cordic (
    input  logic                               i_clk,
    input  logic                               i_en,
    input  logic [gcpc_pkg::MAG_W-1:0]         i_ax,
    input  logic [gcpc_pkg::MAG_W-1:0]         i_ay,
    output logic signed [gcpc_pkg::Z_W-1:0]    o_z
);

    logic signed [gcpc_pkg::CX_W-1:0] s_x [0:gcpc_pkg::CORDIC_STEPS];
    logic signed [gcpc_pkg::CX_W-1:0] s_y [0:gcpc_pkg::CORDIC_STEPS];
    logic signed [gcpc_pkg::Z_W-1:0]  s_z [0:gcpc_pkg::CORDIC_STEPS];
    logic signed [gcpc_pkg::CX_W-1:0] r_x [0:gcpc_pkg::CORDIC_STEPS-1];
    logic signed [gcpc_pkg::CX_W-1:0] r_y [0:gcpc_pkg::CORDIC_STEPS-1];
    logic signed [gcpc_pkg::Z_W-1:0]  r_z [0:gcpc_pkg::CORDIC_STEPS-1];

    // Scale magnitudes up by 2^24
    assign s_x[0] = $signed({4'b0, i_ax, 24'b0});
    assign s_y[0] = $signed({4'b0, i_ay, 24'b0});
    assign s_z[0] = '0;

    for (genvar g = 0; g < gcpc_pkg::CORDIC_STEPS; g++) begin : g_step
        logic signed [gcpc_pkg::CX_W-1:0] w_dx, w_dy;

        assign w_dx = s_y[g] >>> g;
        assign w_dy = s_x[g] >>> g;

        // Rotate toward the x axis, accumulate the angle
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (!s_y[g][gcpc_pkg::CX_W-1]) begin
                    r_x[g] <= s_x[g] + w_dx;
                    r_y[g] <= s_y[g] - w_dy;
                    r_z[g] <= s_z[g] + gcpc_pkg::atan_val(g);
                end else begin
                    r_x[g] <= s_x[g] - w_dx;
                    r_y[g] <= s_y[g] + w_dy;
                    r_z[g] <= s_z[g] - gcpc_pkg::atan_val(g);
                end
            end
        end

        assign s_x[g+1] = r_x[g];
        assign s_y[g+1] = r_y[g];
        assign s_z[g+1] = r_z[g];
    end

    assign o_z = s_z[gcpc_pkg::CORDIC_STEPS];

endmodule

// ----- rtl/core/gcpc_sqrt.sv -----
// Pipelined restoring integer square root of 256*d2, one result bit per stage.
// Same depth as the CORDIC pipeline; depends on gcpc_pkg.
module gcpc_sqrt (
    input  logic                           i_clk,
    input  logic                           i_en,
    input  logic [gcpc_pkg::D2_W-1:0]      i_d2,
    output logic [gcpc_pkg::DIST_W-1:0]    o_root
);

    logic [gcpc_pkg::SQ_W-1:0] s_n [0:gcpc_pkg::CORDIC_STEPS];
    logic [gcpc_pkg::SQ_W-1:0] s_r [0:gcpc_pkg::CORDIC_STEPS];
    logic [gcpc_pkg::SQ_W-1:0] r_n [0:gcpc_pkg::CORDIC_STEPS-1];
    logic [gcpc_pkg::SQ_W-1:0] r_r [0:gcpc_pkg::CORDIC_STEPS-1];

    // Radicand is d2 scaled by 256 for four fraction bits
    assign s_n[0] = {4'b0, i_d2, 8'b0};
    assign s_r[0] = '0;

    for (genvar g = 0; g < gcpc_pkg::CORDIC_STEPS; g++) begin : g_step
        localparam logic [gcpc_pkg::SQ_W-1:0] BIT =
            gcpc_pkg::SQ_W'(1) << (gcpc_pkg::SQ_W - 2 - 2 * g);
        logic [gcpc_pkg::SQ_W-1:0] w_trial;

        assign w_trial = s_r[g] + BIT;

        // Try the next bit, keep it when the remainder allows
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (s_n[g] >= w_trial) begin
                    r_n[g] <= s_n[g] - w_trial;
                    r_r[g] <= (s_r[g] >> 1) + BIT;
                end else begin
                    r_n[g] <= s_n[g];
                    r_r[g] <= s_r[g] >> 1;
                end
            end
        end

        assign s_n[g+1] = r_n[g];
        assign s_r[g+1] = r_r[g];
    end

    // Root of a 44-bit value fits well inside the output field
    assign o_root = s_r[gcpc_pkg::CORDIC_STEPS][gcpc_pkg::DIST_W-1:0];

endmodule

// ----- rtl/core/grid_cell_polar_converter.sv -----
// Grid cell polar converter: takes one cell (row, col) per cycle while the output does not
// stall and returns its centre, distance in Q.4 mm, bearing in 1/64 degree and the
// in-range/unknown flags. The pipeline has 5 front-end stages, 24 CORDIC and square-root
// stages and 1 output register, its depth set by the 24-step CORDIC. A stall on the output
// freezes the whole pipeline; configuration writes are taken at once and should only
// be made while no cell is in flight.
// Depends on gcpc_pkg, gcpc_front, gcpc_cordic and gcpc_sqrt.
module grid_cell_polar_converter (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // tdata: row[8:0], col[17:9], zero pad
    input  logic [23:0] i_s_tdata,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    // tdata: center_x[20:0], center_y[41:21], distance_q4[66:42], bearing[81:67], zero pad
    output logic [87:0] o_m_tdata,
    // tuser: in_range[0], unknown[1]
    output logic [1:0]  o_m_tuser,
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    logic signed [gcpc_pkg::CFG_DATA_W-1:0] r_corner_x, r_corner_y;
    logic [7:0]                             r_cell_size;
    logic [gcpc_pkg::CFG_DATA_W-1:0]        r_max_range, r_min_range;
    logic [gcpc_pkg::SQR_W-1:0]             r_max2, r_min2;
    logic [gcpc_pkg::PIPE_DEPTH-1:0]        r_vld;
    logic                                   w_en;
    gcpc_pkg::t_front                       w_front;
    gcpc_pkg::t_side                        r_side [0:gcpc_pkg::CORDIC_STEPS-1];
    gcpc_pkg::t_side                        w_side_last;
    logic signed [gcpc_pkg::Z_W-1:0]        w_z;
    logic [gcpc_pkg::Z_W-1:0]               w_zc;
    logic [gcpc_pkg::DIST_W-1:0]            w_root;
    logic [gcpc_pkg::BEAR_W:0]              w_p, w_b;
    logic signed [gcpc_pkg::COORD_W-1:0]    r_out_x, r_out_y;
    logic [gcpc_pkg::DIST_W-1:0]            r_out_dist;
    logic [gcpc_pkg::BEAR_W-1:0]            r_out_bear;
    logic                                   r_out_inr;

    // Configuration registers
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_corner_x  <= gcpc_pkg::RST_CORNER_X;
            r_corner_y  <= gcpc_pkg::RST_CORNER_Y;
            r_cell_size <= gcpc_pkg::RST_CELL_SIZE;
            r_max_range <= gcpc_pkg::RST_MAX_RANGE;
            r_min_range <= gcpc_pkg::RST_MIN_RANGE;
        end else if (i_cfg_valid) begin
            case (gcpc_pkg::t_cfg_reg'(i_cfg_index))
                gcpc_pkg::CFG_CORNER_X:  r_corner_x  <= $signed(i_cfg_data);
                gcpc_pkg::CFG_CORNER_Y:  r_corner_y  <= $signed(i_cfg_data);
                gcpc_pkg::CFG_CELL_SIZE: r_cell_size <= i_cfg_data[7:0];
                gcpc_pkg::CFG_MAX_RANGE: r_max_range <= i_cfg_data;
                gcpc_pkg::CFG_MIN_RANGE: r_min_range <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Squared range limits, refreshed every cycle
    always_ff @(posedge i_clk) begin
        r_max2 <= gcpc_pkg::SQR_W'(r_max_range) * gcpc_pkg::SQR_W'(r_max_range);
        r_min2 <= gcpc_pkg::SQR_W'(r_min_range) * gcpc_pkg::SQR_W'(r_min_range);
    end

    // Advance the whole pipeline unless the output holds an untaken transaction
    assign w_en       = !r_vld[gcpc_pkg::PIPE_DEPTH-1] || i_m_tready;
    assign o_s_tready = w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[gcpc_pkg::PIPE_DEPTH-2:0], i_s_tvalid};
        end
    end

    gcpc_front u_front (
        .i_clk      (i_clk),
        .i_en       (w_en),
        .i_row      (i_s_tdata[8:0]),
        .i_col      (i_s_tdata[17:9]),
        .i_corner_x (r_corner_x),
        .i_corner_y (r_corner_y),
        .i_half     (r_cell_size[7:1]),
        .o_front    (w_front)
    );

    gcpc_cordic u_cordic (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_ax  (w_front.ax),
        .i_ay  (w_front.ay),
        .o_z   (w_z)
    );

    gcpc_sqrt u_sqrt (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_d2   (w_front.d2),
        .o_root (w_root)
    );

    // Carry centre and flags alongside the CORDIC stages
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_side[0].x        <= w_front.x;
            r_side[0].y        <= w_front.y;
            r_side[0].in_range <= w_front.grid_ok
                                  && (w_front.d2 >= gcpc_pkg::D2_W'(r_min2))
                                  && (w_front.d2 <  gcpc_pkg::D2_W'(r_max2));
            r_side[0].ax_zero  <= (w_front.ax == '0);
            r_side[0].ay_zero  <= (w_front.ay == '0);
            for (int k = 1; k < gcpc_pkg::CORDIC_STEPS; k++) begin
                r_side[k] <= r_side[k-1];
            end
        end
    end

    assign w_side_last = r_side[gcpc_pkg::CORDIC_STEPS-1];

    // Clamp and round the angle, then fold into the right quadrant
    always_comb begin
        if (w_z[gcpc_pkg::Z_W-1]) begin
            w_zc = '0;
        end else if (w_z > gcpc_pkg::ANG_QUARTER) begin
            w_zc = gcpc_pkg::ANG_QUARTER;
        end else begin
            w_zc = w_z;
        end

        if (w_side_last.ay_zero) begin
            w_p = '0;
        end else if (w_side_last.ax_zero) begin
            w_p = gcpc_pkg::BEAR_QUARTER;
        end else begin
            w_p = (gcpc_pkg::BEAR_W+1)'((w_zc + gcpc_pkg::ANG_ROUND) >> 12);
        end

        if (w_side_last.ax_zero && w_side_last.ay_zero) begin
            w_b = '0;
        end else if (!w_side_last.x[gcpc_pkg::COORD_W-1]
                     && !w_side_last.y[gcpc_pkg::COORD_W-1]) begin
            w_b = w_p;
        end else if (!w_side_last.y[gcpc_pkg::COORD_W-1]) begin
            w_b = gcpc_pkg::BEAR_HALF - w_p;
        end else if (w_side_last.x[gcpc_pkg::COORD_W-1]) begin
            w_b = gcpc_pkg::BEAR_HALF + w_p;
        end else if (w_p == '0) begin
            w_b = '0;
        end else begin
            w_b = gcpc_pkg::BEAR_FULL - w_p;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out_x    <= w_side_last.x;
            r_out_y    <= w_side_last.y;
            r_out_dist <= w_root;
            r_out_bear <= w_b[gcpc_pkg::BEAR_W-1:0];
            r_out_inr  <= w_side_last.in_range;
        end
    end

    assign o_m_tvalid = r_vld[gcpc_pkg::PIPE_DEPTH-1];
    assign o_m_tdata  = {6'b0, r_out_bear, r_out_dist, r_out_y, r_out_x};
    assign o_m_tuser  = {!r_out_inr, r_out_inr};

    // Bearing stays below a full turn
    a_bear_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (r_out_bear < gcpc_pkg::BEAR_FULL[gcpc_pkg::BEAR_W-1:0]))
        else $error("bearing out of range");

    // A centre at the origin has zero distance and zero bearing
    a_origin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && r_out_x == '0 && r_out_y == '0) |->
        (r_out_dist == '0 && r_out_bear == '0))
        else $error("origin cell not at zero");

    // In-range distance lies within the annulus limits
    a_inr_dist: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && r_out_inr) |->
        (r_out_dist < {5'b0, r_max_range, 4'b0} && r_out_dist >= {5'b0, r_min_range, 4'b0}))
        else $error("in-range flag disagrees with distance");

    // A stalled pipeline holds the result it shows
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |=> (o_m_tvalid && $stable(r_out_dist)
        && $stable(r_out_bear)))
        else $error("stalled result changed");

endmodule

// ----- sim/tb_grid_cell_polar_converter.sv -----
// Testbench for grid_cell_polar_converter: drives cells, predicts centre, distance,
// bearing and range flags in a local model and checks every output transaction.
// Depends on gcpc_pkg and the grid_cell_polar_converter RTL.
`timescale 1ns / 100ps

module tb_grid_cell_polar_converter;

    localparam int           CLK_HALF      = 2;
    localparam int           DRAIN_CYCLES  = gcpc_pkg::PIPE_DEPTH + 10;
    localparam int           CYCLE_LIMIT   = 400000;
    localparam logic [2:0]   CFG_UNUSED_IX = 3'd7;

    // Expected result of one cell
    typedef struct {
        logic signed [gcpc_pkg::COORD_W-1:0] cx;
        logic signed [gcpc_pkg::COORD_W-1:0] cy;
        logic [gcpc_pkg::DIST_W-1:0]         dist_q4;
        logic [gcpc_pkg::BEAR_W-1:0]         bear;
        logic                                inr;
        logic                                unk;
    } t_cell_polar;

    typedef struct {
        logic [gcpc_pkg::IDX_W-1:0] row;
        logic [gcpc_pkg::IDX_W-1:0] col;
    } t_cell_idx;

    logic        i_clk;
    logic        i_rst_n;
    logic [23:0] i_s_tdata;
    logic        i_s_tvalid;
    logic        o_s_tready;
    logic [87:0] o_m_tdata;
    logic [1:0]  o_m_tuser;
    logic        o_m_tvalid;
    logic        i_m_tready;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index;
    logic [15:0] i_cfg_data;

    // Shadow copy of the configuration registers
    logic signed [15:0] sh_corner_x;
    logic signed [15:0] sh_corner_y;
    logic [7:0]         sh_cell_size;
    logic [15:0]        sh_max_range;
    logic [15:0]        sh_min_range;

    t_cell_idx   cells_to_send[$];
    t_cell_polar polar_expected[$];
    int          n_errors;
    int          n_checked;
    int          n_cycles;
    int          send_gap;
    int          recv_stall;
    bit          send_burst;
    bit          recv_burst;

    longint signed atan_units[gcpc_pkg::CORDIC_STEPS] = '{
        11796480, 6963869, 3679517, 1867780, 937515, 469214, 234664, 117339,
        58671, 29335, 14668, 7334, 3667, 1833, 917, 458,
        229, 115, 57, 29, 14, 7, 4, 2
    };

    grid_cell_polar_converter uut (.*);

    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // Integer square root, bit by bit
    function automatic longint unsigned int_sqrt(input longint unsigned n);
        longint unsigned res;
        longint unsigned b;
        res = 0;
        b   = 64'd1 << 62;
        while (b > n) b >>= 2;
        while (b != 0) begin
            if (n >= res + b) begin
                n   = n - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b >>= 2;
        end
        return res;
    endfunction

    // Centre, distance, bearing and range flags of one cell under current registers
    function automatic t_cell_polar polar_of_cell(input t_cell_idx c);
        t_cell_polar   r;
        longint signed h, x, y, ax, ay, cx_acc, cy_acc, z, dx, dy, p, b;
        longint unsigned d2, dist_q;
        h  = longint'(sh_cell_size >> 1);
        x  = longint'(sh_corner_x) + (2 * longint'(c.row) + 1) * h;
        y  = longint'(sh_corner_y) - (2 * longint'(c.col) + 1) * h;
        ax = (x < 0) ? -x : x;
        ay = (y < 0) ? -y : y;
        d2 = ax * ax + ay * ay;
        dist_q = int_sqrt(d2 << 8);
        if (dist_q > 64'd33554431) dist_q = 64'd33554431;
        if (x == 0 && y == 0) begin
            b = 0;
        end else begin
            if (ay == 0) begin
                p = 0;
            end else if (ax == 0) begin
                p = gcpc_pkg::BEAR_QUARTER;
            end else begin
                cx_acc = ax <<< 24;
                cy_acc = ay <<< 24;
                z = 0;
                for (int i = 0; i < gcpc_pkg::CORDIC_STEPS; i++) begin
                    dx = cy_acc >>> i;
                    dy = cx_acc >>> i;
                    if (cy_acc >= 0) begin
                        cx_acc += dx; cy_acc -= dy; z += atan_units[i];
                    end else begin
                        cx_acc -= dx; cy_acc += dy; z -= atan_units[i];
                    end
                end
                if (z < 0) z = 0;
                if (z > gcpc_pkg::ANG_QUARTER) z = gcpc_pkg::ANG_QUARTER;
                p = (z + 2048) >>> 12;
            end
            // Fold the first-quadrant angle into the full circle
            if (x >= 0 && y >= 0)  b = p;
            else if (x < 0 && y >= 0) b = gcpc_pkg::BEAR_HALF - p;
            else if (x < 0)        b = gcpc_pkg::BEAR_HALF + p;
            else                   b = gcpc_pkg::BEAR_FULL - p;
            if (b >= gcpc_pkg::BEAR_FULL) b -= gcpc_pkg::BEAR_FULL;
        end
        r.cx      = x[gcpc_pkg::COORD_W-1:0];
        r.cy      = y[gcpc_pkg::COORD_W-1:0];
        r.dist_q4 = dist_q[gcpc_pkg::DIST_W-1:0];
        r.bear    = b[gcpc_pkg::BEAR_W-1:0];
        r.inr     = (d2 >= longint'(sh_min_range) * sh_min_range) &&
                    (d2 < longint'(sh_max_range) * sh_max_range) &&
                    (int'(c.row) < gcpc_pkg::GRID_DIM) &&
                    (int'(c.col) < gcpc_pkg::GRID_DIM);
        r.unk     = !r.inr;
        return r;
    endfunction

    // Input driver: hold on stall, otherwise take the next cell after a random gap
    always @(posedge i_clk) begin
        t_cell_idx nxt;
        t_cell_idx cur;
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
            send_gap   <= 0;
        end else if (!(i_s_tvalid && !o_s_tready)) begin
            if (i_s_tvalid) begin
                cur.row = i_s_tdata[8:0];
                cur.col = i_s_tdata[17:9];
                polar_expected = {polar_expected, polar_of_cell(cur)};
                if ($urandom_range(0, 31) == 0) send_burst <= ~send_burst;
            end
            if (send_gap > 0) begin
                send_gap   <= send_gap - 1;
                i_s_tvalid <= 1'b0;
            end else if (cells_to_send.size() > 0) begin
                nxt = cells_to_send.pop_front();
                i_s_tvalid <= 1'b1;
                i_s_tdata  <= {6'd0, nxt.col, nxt.row};
                send_gap   <= send_burst ? 0 : $urandom_range(0, 3);
            end else begin
                i_s_tvalid <= 1'b0;
            end
        end
    end

    // Output monitor: compare each transaction with the oldest expectation
    always @(posedge i_clk) begin
        t_cell_polar e;
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
            recv_stall <= 0;
        end else begin
            if (o_m_tvalid && i_m_tready) begin
                if (polar_expected.size() == 0) begin
                    $error("result with no cell pending");
                    n_errors++;
                end else begin
                    e = polar_expected.pop_front();
                    n_checked++;
                    if (o_m_tdata[20:0] !== e.cx) begin
                        $error("center_x: expected %0d, got %0d", e.cx,
                               $signed(o_m_tdata[20:0]));
                        n_errors++;
                    end
                    if (o_m_tdata[41:21] !== e.cy) begin
                        $error("center_y: expected %0d, got %0d", e.cy,
                               $signed(o_m_tdata[41:21]));
                        n_errors++;
                    end
                    if (o_m_tdata[66:42] !== e.dist_q4) begin
                        $error("distance_q4: expected %0d, got %0d", e.dist_q4,
                               o_m_tdata[66:42]);
                        n_errors++;
                    end
                    if (o_m_tdata[81:67] !== e.bear) begin
                        $error("bearing: expected %0d, got %0d", e.bear, o_m_tdata[81:67]);
                        n_errors++;
                    end
                    if (o_m_tuser[0] !== e.inr) begin
                        $error("in_range: expected %0d, got %0d", e.inr, o_m_tuser[0]);
                        n_errors++;
                    end
                    if (o_m_tuser[1] !== e.unk) begin
                        $error("unknown: expected %0d, got %0d", e.unk, o_m_tuser[1]);
                        n_errors++;
                    end
                end
                recv_stall <= recv_burst ? 0 : $urandom_range(0, 3);
                if ($urandom_range(0, 31) == 0) recv_burst <= ~recv_burst;
                i_m_tready <= 1'b0;
            end else if (recv_stall > 0) begin
                recv_stall <= recv_stall - 1;
                i_m_tready <= 1'b0;
            end else begin
                i_m_tready <= 1'b1;
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        n_cycles <= n_cycles + 1;
        if (n_cycles > CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            gcpc_pkg::CFG_CORNER_X:  sh_corner_x  = val;
            gcpc_pkg::CFG_CORNER_Y:  sh_corner_y  = val;
            gcpc_pkg::CFG_CELL_SIZE: sh_cell_size = val[7:0];
            gcpc_pkg::CFG_MAX_RANGE: sh_max_range = val;
            gcpc_pkg::CFG_MIN_RANGE: sh_min_range = val;
            default: ;
        endcase
        i_cfg_valid <= 1'b0;
    endtask

    task automatic set_grid(input logic [15:0] cx, input logic [15:0] cy,
                            input logic [15:0] cs, input logic [15:0] mx,
                            input logic [15:0] mn);
        write_reg(gcpc_pkg::CFG_CORNER_X, cx);
        write_reg(gcpc_pkg::CFG_CORNER_Y, cy);
        write_reg(gcpc_pkg::CFG_CELL_SIZE, cs);
        write_reg(gcpc_pkg::CFG_MAX_RANGE, mx);
        write_reg(gcpc_pkg::CFG_MIN_RANGE, mn);
    endtask

    task automatic queue_cell(input int r, input int c);
        t_cell_idx ci;
        ci.row = r[gcpc_pkg::IDX_W-1:0];
        ci.col = c[gcpc_pkg::IDX_W-1:0];
        cells_to_send = {cells_to_send, ci};
    endtask

    task automatic queue_random(input int n);
        repeat (n) queue_cell($urandom_range(0, 511), $urandom_range(0, 511));
    endtask

    // Wait for the pipeline to empty before touching registers
    task automatic drain_pipe();
        while (cells_to_send.size() > 0 || i_s_tvalid || polar_expected.size() > 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    initial begin
        i_rst_n     = 1'b0;
        i_s_tvalid  = 1'b0;
        i_s_tdata   = '0;
        i_m_tready  = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data  = '0;
        n_errors    = 0;
        n_checked   = 0;
        n_cycles    = 0;
        send_burst  = 0;
        recv_burst  = 0;
        sh_corner_x  = gcpc_pkg::RST_CORNER_X;
        sh_corner_y  = gcpc_pkg::RST_CORNER_Y;
        sh_cell_size = gcpc_pkg::RST_CELL_SIZE;
        sh_max_range = gcpc_pkg::RST_MAX_RANGE;
        sh_min_range = gcpc_pkg::RST_MIN_RANGE;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset registers: index extremes and a cell near the origin
        queue_cell(0, 0);
        queue_cell(511, 511);
        queue_cell(0, 511);
        queue_cell(511, 0);
        queue_cell(150, 150);
        queue_cell(149, 149);
        queue_cell(170, 300);
        queue_random(250);
        drain_pipe();

        // Cells of size two with corner next to origin: origin, both axes, full annulus
        set_grid(-16'sd1, 16'sd1, 16'd2, 16'hFFFF, 16'd0);
        queue_cell(0, 0);
        queue_cell(0, 7);
        queue_cell(9, 0);
        queue_cell(0, 511);
        queue_cell(511, 0);
        queue_cell(340, 170);
        queue_random(250);
        drain_pipe();

        // Extreme corner, largest cell, empty annulus; ignored register write
        set_grid(16'h8000, 16'h7FFF, 16'd255, 16'hFFFF, 16'hFFFF);
        write_reg(CFG_UNUSED_IX, 16'h5555);
        queue_cell(0, 0);
        queue_cell(511, 511);
        queue_cell(0, 511);
        queue_cell(511, 0);
        queue_random(200);
        drain_pipe();

        // Degenerate cell sizes: every centre is the corner
        set_grid(16'h7FFF, 16'h8000, 16'd1, 16'd0, 16'd0);
        queue_cell(511, 511);
        queue_random(40);
        drain_pipe();
        set_grid(16'd0, 16'd0, 16'd0, 16'd100, 16'd0);
        queue_cell(3, 4);
        queue_random(40);
        drain_pipe();

        // Random grids, fully random and then sized so the annulus cuts through the cells
        repeat (6) begin
            set_grid($urandom_range(0, 65535), $urandom_range(0, 65535),
                     $urandom_range(2, 255), $urandom_range(0, 65535),
                     $urandom_range(0, 40000));
            queue_random(60);
            drain_pipe();
            set_grid(-($urandom_range(0, 3000)), $urandom_range(0, 3000),
                     $urandom_range(2, 24), $urandom_range(1000, 6000),
                     $urandom_range(0, 800));
            queue_random(80);
            drain_pipe();
        end

        write_reg(CFG_UNUSED_IX, 16'hAAAA);
        queue_random(50);
        drain_pipe();

        if (polar_expected.size() > 0) begin
            $error("%0d expected results never arrived", polar_expected.size());
            n_errors++;
        end
        $display("Converted %0d cells across reset, corner, degenerate and random grids,",
                 n_checked);
        $display("with random gaps on input and output; %0d mismatches.", n_errors);
        if (n_errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
